/* sv/pfc_pkg.sv */
// Shared types, constants and helper functions of the Playfair cipher stream.
package pfc_pkg;

  // Alphabet and grid dimensions.
  localparam int unsigned LETTERS    = 26;
  localparam int unsigned GRID_CELLS = 25;
  localparam int unsigned GRID_SIDE  = 5;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned RC_W       = 3;
  localparam int unsigned CHAR_W     = 7;

  // Letter indexes with a special role.
  localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;

  // ASCII anchors.
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_MODE = 1'b0;

  // Input operation codes.
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_KEY    = 3'd1,
    OP_FINISH = 3'd2,
    OP_TEXT   = 3'd3,
    OP_END    = 3'd4
  } op_e;

  // Decoded input byte.
  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] letter;
  } letter_t;

  // Row and column of a grid cell.
  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } rc_t;

  // One result transaction.
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } result_t;

  // Results handed from the engine to the output queue.
  typedef struct packed {
    logic    push;
    logic    two;
    result_t r0;
    result_t r1;
  } push_t;

  // Folds case, drops non-letters and maps j onto i.
  function automatic letter_t to_letter(input logic [7:0] b);
    logic [7:0] c;
    letter_t    res;
    c = b;
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      c = b + ASCII_CASE;
    end
    res.valid  = (c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z);
    res.letter = LETTER_W'(c - ASCII_LOWER_A);
    if (res.letter == LETTER_J) begin
      res.letter = LETTER_I;
    end
    return res;
  endfunction

  // Splits a grid position into row and column.
  function automatic rc_t pos_to_rc(input logic [POS_W-1:0] pos);
    rc_t res;
    res = '0;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        if (pos == POS_W'(r * GRID_SIDE + c)) begin
          res.row = RC_W'(r);
          res.col = RC_W'(c);
        end
      end
    end
    return res;
  endfunction

  // Adds the cipher shift modulo five: one to encipher, four to decipher.
  function automatic logic [RC_W-1:0] shift_mod5(input logic [RC_W-1:0] v, input logic dec);
    logic [RC_W-1:0] res;
    if (dec) begin
      res = (v == '0) ? RC_W'(GRID_SIDE - 1) : v - 1'b1;
    end else begin
      res = (v == RC_W'(GRID_SIDE - 1)) ? '0 : v + 1'b1;
    end
    return res;
  endfunction

  // Grid position of a row and column.
  function automatic logic [POS_W-1:0] rc_to_pos(input logic [RC_W-1:0] row,
                                                 input logic [RC_W-1:0] col);
    return {row[2:0], 2'b00} + POS_W'(row) + POS_W'(col);
  endfunction

  // ASCII code of a letter index.
  function automatic logic [CHAR_W-1:0] letter_to_char(input logic [LETTER_W-1:0] l);
    return CHAR_W'(ASCII_LOWER_A) + CHAR_W'(l);
  endfunction

endpackage

/* sv/pfc_in_if.sv */
// Input channel: operation code and raw byte with a valid/ready handshake.
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] char_byte;

  modport source (output valid, output op, output char_byte, input ready);
  modport sink (input valid, input op, input char_byte, output ready);
endinterface

/* sv/pfc_out_if.sv */
// Output channel: one letter and its last flag with a valid/ready handshake.
interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

/* sv/pfc_ram.sv */
// Generic RAM with one write port and two registered read ports.
module pfc_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* sv/pfc_outq.sv */
// Two-entry result queue that drives the output channel.
module pfc_outq
  import pfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic             empty_o,
  pfc_out_if.source        out_o
);

  logic [1:0] count_q;
  result_t    e0_q;
  result_t    e1_q;
  logic       pop;

  assign pop         = out_o.valid && out_o.ready;
  assign empty_o     = (count_q == 2'd0);
  assign out_o.valid = (count_q != 2'd0);
  assign out_o.out_char = e0_q.out_char;
  assign out_o.last     = e0_q.last;

  // Fill level; the engine pushes only into an empty queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push_i.push) begin
      count_q <= push_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      count_q <= count_q - 2'd1;
    end
  end

  // Entries shift toward the head as results are taken.
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      e0_q <= push_i.r0;
      e1_q <= push_i.r1;
    end else if (pop) begin
      e0_q <= e1_q;
    end
  end

endmodule

/* sv/pfc_engine.sv */
// Key grid and position memories with the sequencer that builds and reads them.
module pfc_engine
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  pfc_in_if.sink     in_i,
  input  logic       q_empty_i,
  output push_t      push_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_POS,
    S_GRID,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [LETTERS-1:0]  used_q;
  logic [POS_W-1:0]    fill_q;
  logic                pend_v_q;
  logic [LETTER_W-1:0] pend_l_q;
  logic                dec_q;
  logic [LETTER_W-1:0] fill_c_q;
  logic [LETTER_W-1:0] res0_q;
  logic [LETTER_W-1:0] res1_q;
  logic                two_q;

  logic                accept;
  op_e                 op;
  letter_t             in_l;
  logic [LETTER_W-1:0] wletter;
  logic                cand;
  logic                place;
  logic [LETTER_W-1:0] pos_raddr_b;
  logic [POS_W-1:0]    pos_rd_a;
  logic [POS_W-1:0]    pos_rd_b;
  logic [LETTER_W-1:0] grid_rd_a;
  logic [LETTER_W-1:0] grid_rd_b;
  rc_t                 rc_a;
  rc_t                 rc_b;
  logic [POS_W-1:0]    g0;
  logic [POS_W-1:0]    g1;
  logic                full;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);
  assign in_l       = to_letter(in_i.char_byte);
  assign full       = (fill_q >= POS_W'(GRID_CELLS));

  // Placement of one letter into the grid, from a key byte or the fill sweep.
  always_comb begin
    wletter = in_l.letter;
    cand    = accept && (op == OP_KEY) && in_l.valid;
    if (state_q == S_FILL) begin
      wletter = fill_c_q;
      cand    = (fill_c_q != LETTER_J);
    end
  end
  assign place = cand && !full && !used_q[wletter];

  // Second position read: the partner letter, or x where a filler is inserted.
  assign pos_raddr_b = ((op == OP_END) || (!mode_i && pend_l_q == in_l.letter)) ?
                       LETTER_X : in_l.letter;

  // Row, column and rectangle rules on the two positions.
  always_comb begin
    rc_a = pos_to_rc(pos_rd_a);
    rc_b = pos_to_rc(pos_rd_b);
    if (rc_a.row == rc_b.row) begin
      g0 = rc_to_pos(rc_a.row, shift_mod5(rc_a.col, dec_q));
      g1 = rc_to_pos(rc_b.row, shift_mod5(rc_b.col, dec_q));
    end else if (rc_a.col == rc_b.col) begin
      g0 = rc_to_pos(shift_mod5(rc_a.row, dec_q), rc_a.col);
      g1 = rc_to_pos(shift_mod5(rc_b.row, dec_q), rc_b.col);
    end else begin
      g0 = rc_to_pos(rc_a.row, rc_b.col);
      g1 = rc_to_pos(rc_b.row, rc_a.col);
    end
  end

  // Grid cell to letter.
  pfc_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk_i     (clk_i),
    .we_i      (place),
    .waddr_i   (fill_q),
    .wdata_i   (wletter),
    .raddr_a_i (g0),
    .raddr_b_i (g1),
    .rdata_a_o (grid_rd_a),
    .rdata_b_o (grid_rd_b)
  );

  // Letter to grid cell.
  pfc_ram #(
    .WIDTH (POS_W),
    .DEPTH (LETTERS)
  ) u_pos (
    .clk_i     (clk_i),
    .we_i      (place),
    .waddr_i   (wletter),
    .wdata_i   (fill_q),
    .raddr_a_i (pend_l_q),
    .raddr_b_i (pos_raddr_b),
    .rdata_a_o (pos_rd_a),
    .rdata_b_o (pos_rd_b)
  );

  // Results toward the output queue.
  always_comb begin
    push_o.push        = (state_q == S_EMIT) && q_empty_i;
    push_o.two         = two_q;
    push_o.r0.out_char = letter_to_char(res0_q);
    push_o.r0.last     = !two_q;
    push_o.r1.out_char = letter_to_char(res1_q);
    push_o.r1.last     = 1'b1;
  end

  // Sequencer, key state and pending letter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      fill_q   <= '0;
      pend_v_q <= 1'b0;
      pend_l_q <= '0;
      dec_q    <= 1'b0;
      fill_c_q <= '0;
      res0_q   <= '0;
      res1_q   <= '0;
      two_q    <= 1'b0;
    end else begin
      if (place) begin
        used_q[wletter] <= 1'b1;
        fill_q          <= fill_q + 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            dec_q <= mode_i;
            case (op)
              OP_CLEAR: begin
                used_q   <= '0;
                fill_q   <= '0;
                pend_v_q <= 1'b0;
                pend_l_q <= '0;
              end
              OP_FINISH: begin
                if (!full) begin
                  fill_c_q <= '0;
                  state_q  <= S_FILL;
                end
              end
              OP_TEXT: begin
                if (in_l.valid) begin
                  if (!pend_v_q) begin
                    pend_v_q <= 1'b1;
                    pend_l_q <= in_l.letter;
                  end else if (pend_l_q == in_l.letter && pend_l_q == LETTER_X) begin
                    // A literal xx pair passes through unchanged.
                    res0_q  <= LETTER_X;
                    res1_q  <= LETTER_X;
                    two_q   <= 1'b1;
                    state_q <= S_EMIT;
                    if (mode_i) begin
                      pend_v_q <= 1'b0;
                      pend_l_q <= '0;
                    end
                  end else begin
                    state_q <= S_POS;
                    // A doubled letter while enciphering keeps its second copy pending.
                    if (mode_i || pend_l_q != in_l.letter) begin
                      pend_v_q <= 1'b0;
                      pend_l_q <= '0;
                    end
                  end
                end
              end
              OP_END: begin
                if (pend_v_q) begin
                  res0_q   <= pend_l_q;
                  two_q    <= 1'b0;
                  pend_v_q <= 1'b0;
                  pend_l_q <= '0;
                  // The odd tail is emitted as is when deciphering or when it is x.
                  state_q  <= (mode_i || pend_l_q == LETTER_X) ? S_EMIT : S_POS;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FILL: begin
          fill_c_q <= fill_c_q + 1'b1;
          if (fill_c_q == LETTER_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_POS: begin
          state_q <= S_GRID;
        end
        S_GRID: begin
          res0_q  <= grid_rd_a;
          res1_q  <= grid_rd_b;
          two_q   <= 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (q_empty_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/playfair_cipher_stream.sv */
// Top level of the Playfair cipher stream: configuration port, engine and output queue.
//
// Usage: bytes enter on in_i with an operation code (clear key, key byte,
// finish key, text byte, end of message). Lower-case letters leave on out_o,
// one per transaction, with last set on the final letter caused by an input.
// The mode register at byte address 0 selects encipher (0) or decipher (1)
// and is written over the APB-style port; the user must write it only while
// the block is idle, which the block does not enforce. Key bytes, clear and
// unpaired text bytes are handled in the idle state. A text byte that completes
// a pair goes through accept and position read, grid read, capture, and
// hand-off to the output queue. A literal xx pair and an odd tail sent as
// is go through accept and hand-off; an odd tail padded with x goes through
// the same steps as a pair. Finish key sweeps the alphabet one letter a cycle
// through both memories. Results reach out_o in the cycle after hand-off.
// Reset clears the key state, the pending letter, the queue and the mode.
// The grid memories are not cleared; a key must be built before text.
// When the receiver stalls, up to two results wait in the queue while the
// next input is accepted; an item that produces results then waits until
// the queue has drained.
module playfair_cipher_stream
  import pfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  pfc_in_if.sink             in_i,
  pfc_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic  mode_q;
  logic  q_empty;
  push_t push;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  // Grid build and lookup.
  pfc_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .in_i      (in_i),
    .q_empty_i (q_empty),
    .push_o    (push)
  );

  // Result queue.
  pfc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .empty_o (q_empty),
    .out_o   (out_o)
  );

endmodule
